// ===== rtl/core/ptfa_pkg.sv =====
`timescale 1ns / 1ps
// Package for the partition table fit allocator: field widths, table geometry,
// status, unit, policy and configuration register codes. No dependencies.
package ptfa_pkg;

    // Table geometry.
    localparam int SLOT_COUNT   = 4;
    localparam int HEADER_BYTES = 128;
    // The header counts as one more used range ahead of the slots.
    localparam int RANGE_COUNT  = SLOT_COUNT + 1;
    localparam int RIDX_W       = $clog2(RANGE_COUNT);

    // Field widths.
    localparam int BYTE_W      = 31;
    localparam int UNIT_W      = 2;
    localparam int TAG_W       = 2;
    localparam int NAME_W      = 64;
    localparam int NAME_PAD_W  = 8;
    localparam int STATUS_W    = 3;
    localparam int SLOT_IDX_W  = 2;
    localparam int POLICY_W    = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 31;

    // Shared adder width: sums of two 31-bit values and signed differences.
    localparam int ALU_W = BYTE_W + 3;

    // Unit conversion shifts.
    localparam int KIB_SHIFT = 10;
    localparam int MIB_SHIFT = 20;

    // Size units.
    localparam logic [UNIT_W-1:0] UNIT_BYTE = 2'd0;
    localparam logic [UNIT_W-1:0] UNIT_KIB  = 2'd1;

    // Partition kinds.
    localparam logic KIND_EXTENDED = 1'b1;

    // Placement policies; any other code acts as worst fit.
    localparam logic [POLICY_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] FIT_WORST = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_SIZE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY = 1'd1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_CREATED    = 3'd0,
        STAT_DUP_NAME   = 3'd1,
        STAT_TABLE_FULL = 3'd2,
        STAT_EXT_EXISTS = 3'd3,
        STAT_NO_SPACE   = 3'd4
    } status_t;

endpackage

// ===== rtl/core/partition_table_fit_allocator.sv =====
`timescale 1ns / 1ps
// Top level of the partition table fit allocator: slot table, request checks,
// range ranking and gap scan around one shared adder. Depends on ptfa_pkg.

// The block keeps a table of primary partition slots over a disk whose first
// bytes hold the table header, and answers every request transaction with one
// result transaction. A request that is a duplicate name, meets a full table,
// asks for a second extended partition or has a size of zero or one that does
// not fit in 31 bits is answered from the check step. Any other request ranks
// the used ranges by start address (one comparison per pair of ranges), then
// walks the gaps in address order, each with an end step, a gap step and a fit
// step, plus a pick step when best or worst fit must compare against the gap
// kept so far, and finishes in a final step once the output register is free.
// The gap that first becomes the candidate never needs that comparison. Every
// step of the ranking and the gap walk goes through one 34-bit adder. The input
// stalls from acceptance until the result has been loaded into the output
// register; that register lets the next request come in while a result still
// waits to be taken. Configuration writes take effect at once and are expected
// only while no request is in flight.
module partition_table_fit_allocator (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [ptfa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptfa_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Request channel.
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ptfa_pkg::BYTE_W-1:0]         size_value,
    input  logic [ptfa_pkg::UNIT_W-1:0]         size_unit,
    input  logic                                part_kind,
    input  logic [ptfa_pkg::TAG_W-1:0]          part_fit_tag,
    input  logic [ptfa_pkg::NAME_W-1:0]         name_high,
    input  logic [ptfa_pkg::NAME_W-1:0]         name_low,
    // Result channel.
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ptfa_pkg::STATUS_W-1:0]       status,
    output logic [ptfa_pkg::SLOT_IDX_W-1:0]     slot_index,
    output logic [ptfa_pkg::BYTE_W-1:0]         start_byte,
    output logic [ptfa_pkg::BYTE_W-1:0]         byte_size
);

    localparam int S = ptfa_pkg::SLOT_COUNT;
    localparam int R = ptfa_pkg::RANGE_COUNT;
    localparam int RW = ptfa_pkg::RIDX_W;
    localparam int BW = ptfa_pkg::BYTE_W;
    localparam int AW = ptfa_pkg::ALU_W;
    localparam int NW = ptfa_pkg::NAME_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RANK,
        S_SCAN_END,
        S_SCAN_GAP,
        S_SCAN_FIT,
        S_SCAN_PICK,
        S_FINISH
    } state_t;

    // Sequencer and output registers.
    state_t                          state_reg, state_next;
    logic                            out_valid_reg, out_valid_next;
    ptfa_pkg::status_t               status_reg, status_next;
    logic [ptfa_pkg::SLOT_IDX_W-1:0] slot_reg, slot_next;
    logic [BW-1:0]                   start_reg, start_next;
    logic [BW-1:0]                   bytes_out_reg, bytes_out_next;

    // Configuration registers.
    logic [BW-1:0]                   disk_size_reg, disk_size_next;
    logic [ptfa_pkg::POLICY_W-1:0]   fit_policy_reg, fit_policy_next;

    // Ranking and gap scan.
    logic [RW-1:0]                   rank_reg [R];
    logic [RW-1:0]                   rank_next [R];
    logic [RW-1:0]                   pa_reg, pa_next;
    logic [RW-1:0]                   pb_reg, pb_next;
    logic [RW-1:0]                   scan_reg, scan_next;
    logic [RW-1:0]                   last_reg, last_next;
    logic [AW-1:0]                   gs_reg, gs_next;
    logic [AW-1:0]                   gz_reg, gz_next;
    logic [AW-1:0]                   best_size_reg, best_size_next;
    logic [BW-1:0]                   best_start_reg, best_start_next;
    logic                            found_reg, found_next;

    // Latched request.
    logic [BW-1:0]                   req_bytes_reg;
    logic                            req_ovf_reg;
    logic                            req_kind_reg;
    logic [ptfa_pkg::TAG_W-1:0]      req_tag_reg;
    logic [NW-1:0]                   req_name_high_reg;
    logic [NW-1:0]                   req_name_low_reg;

    // Slot table. A slot is in use when its size is nonzero.
    logic [BW-1:0]                   entry_start_reg [S];
    logic [BW-1:0]                   entry_size_reg [S];
    logic                            entry_ext_reg [S];
    logic [ptfa_pkg::TAG_W-1:0]      entry_tag_reg [S];
    logic [NW-1:0]                   entry_name_high_reg [S];
    logic [NW-1:0]                   entry_name_low_reg [S];

    logic                            tbl_we;
    logic [ptfa_pkg::SLOT_IDX_W-1:0] free_slot;

    logic                            accept;
    logic                            out_free;
    logic [BW-1:0]                   conv_bytes;
    logic                            conv_ovf;
    logic                            dup;
    logic                            has_ext;
    logic [RW-1:0]                   used_cnt;

    logic [BW-1:0]                   rng_start [R];
    logic [BW-1:0]                   rng_size [R];
    logic                            rng_used [R];
    logic [BW-1:0]                   cur_start;
    logic [BW-1:0]                   cur_size;
    logic [BW-1:0]                   nxt_start;
    logic [BW-1:0]                   gap_end;

    logic [AW-1:0]                   alu_a, alu_b, alu_res;
    logic                            alu_sub;
    logic                            alu_neg, alu_zero;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot_index = slot_reg;
    assign start_byte = start_reg;
    assign byte_size  = bytes_out_reg;

    // Unit conversion; unit code three is taken as mebibytes.
    always_comb
    begin
        case (size_unit)
            ptfa_pkg::UNIT_BYTE:
            begin
                conv_bytes = size_value;
                conv_ovf   = 1'b0;
            end
            ptfa_pkg::UNIT_KIB:
            begin
                conv_bytes = BW'(size_value << ptfa_pkg::KIB_SHIFT);
                conv_ovf   = |(size_value >> (BW - ptfa_pkg::KIB_SHIFT));
            end
            default:
            begin
                conv_bytes = BW'(size_value << ptfa_pkg::MIB_SHIFT);
                conv_ovf   = |(size_value >> (BW - ptfa_pkg::MIB_SHIFT));
            end
        endcase
    end

    // Table summary used by the request checks.
    always_comb
    begin
        dup      = 1'b0;
        has_ext  = 1'b0;
        used_cnt = '0;
        for (int i = 0; i < S; i++)
        begin
            if (entry_size_reg[i] != '0)
            begin
                used_cnt = used_cnt + 1'b1;
                if (entry_ext_reg[i])
                begin
                    has_ext = 1'b1;
                end
                if (entry_name_high_reg[i] == req_name_high_reg
                    && entry_name_low_reg[i] == req_name_low_reg)
                begin
                    dup = 1'b1;
                end
            end
        end
    end

    // Lowest free slot.
    always_comb
    begin
        free_slot = '0;
        for (int i = S - 1; i >= 0; i--)
        begin
            if (entry_size_reg[i] == '0)
            begin
                free_slot = ptfa_pkg::SLOT_IDX_W'(i);
            end
        end
    end

    // Range list: the header at index zero, then one range per slot.
    always_comb
    begin
        rng_start[0] = '0;
        rng_size[0]  = BW'(ptfa_pkg::HEADER_BYTES);
        rng_used[0]  = 1'b1;
        for (int k = 1; k < R; k++)
        begin
            rng_start[k] = entry_start_reg[k-1];
            rng_size[k]  = entry_size_reg[k-1];
            rng_used[k]  = (entry_size_reg[k-1] != '0);
        end
    end

    // Pick the ranges ranked at the current scan position and the one after.
    always_comb
    begin
        cur_start = '0;
        cur_size  = '0;
        nxt_start = '0;
        for (int k = 0; k < R; k++)
        begin
            if (rng_used[k] && rank_reg[k] == scan_reg)
            begin
                cur_start = cur_start | rng_start[k];
                cur_size  = cur_size | rng_size[k];
            end
            if (rng_used[k] && rank_reg[k] == RW'(scan_reg + 1'b1))
            begin
                nxt_start = nxt_start | rng_start[k];
            end
        end
    end

    // The last gap runs to the end of the disk.
    assign gap_end = (scan_reg == last_reg) ? disk_size_reg : nxt_start;

    // Shared adder, operands chosen by the sequencer step.
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        case (state_reg)
            S_RANK:
            begin
                alu_a = AW'(rng_start[pb_reg]);
                alu_b = AW'(rng_start[pa_reg]);
            end
            S_SCAN_END:
            begin
                alu_a   = AW'(cur_start);
                alu_b   = AW'(cur_size);
                alu_sub = 1'b0;
            end
            S_SCAN_GAP:
            begin
                alu_a = AW'(gap_end);
                alu_b = gs_reg;
            end
            S_SCAN_FIT:
            begin
                alu_a = gz_reg;
                alu_b = AW'(req_bytes_reg);
            end
            S_SCAN_PICK:
            begin
                alu_a = gz_reg;
                alu_b = best_size_reg;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
        alu_res  = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
        alu_neg  = alu_res[AW-1];
        alu_zero = (alu_res == '0);
    end

    // Sequencer next state.
    always_comb
    begin
        logic               take;
        logic               advance;
        logic               reject;
        ptfa_pkg::status_t  reject_code;

        state_next      = state_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        slot_next       = slot_reg;
        start_next      = start_reg;
        bytes_out_next  = bytes_out_reg;
        disk_size_next  = disk_size_reg;
        fit_policy_next = fit_policy_reg;
        rank_next       = rank_reg;
        pa_next         = pa_reg;
        pb_next         = pb_reg;
        scan_next       = scan_reg;
        last_next       = last_reg;
        gs_next         = gs_reg;
        gz_next         = gz_reg;
        best_size_next  = best_size_reg;
        best_start_next = best_start_reg;
        found_next      = found_reg;
        tbl_we          = 1'b0;
        take            = 1'b0;
        advance         = 1'b0;
        reject          = 1'b1;
        reject_code     = ptfa_pkg::STAT_NO_SPACE;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // Checks in priority order; size problems come last.
                if (dup)
                begin
                    reject_code = ptfa_pkg::STAT_DUP_NAME;
                end
                else if (used_cnt == RW'(S))
                begin
                    reject_code = ptfa_pkg::STAT_TABLE_FULL;
                end
                else if (req_kind_reg == ptfa_pkg::KIND_EXTENDED && has_ext)
                begin
                    reject_code = ptfa_pkg::STAT_EXT_EXISTS;
                end
                else if (req_ovf_reg || req_bytes_reg == '0)
                begin
                    reject_code = ptfa_pkg::STAT_NO_SPACE;
                end
                else
                begin
                    reject = 1'b0;
                end

                for (int k = 0; k < R; k++)
                begin
                    rank_next[k] = '0;
                end
                pa_next    = '0;
                pb_next    = RW'(1);
                scan_next  = '0;
                last_next  = used_cnt;
                found_next = 1'b0;

                if (!reject)
                begin
                    state_next = S_RANK;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = reject_code;
                    slot_next      = '0;
                    start_next     = '0;
                    bytes_out_next = req_bytes_reg;
                    state_next     = S_IDLE;
                end
            end
            S_RANK:
            begin
                // The later range in slot order goes first only on a strictly
                // lower start, which keeps the order stable.
                if (rng_used[pa_reg] && rng_used[pb_reg])
                begin
                    if (alu_neg)
                    begin
                        rank_next[pa_reg] = rank_reg[pa_reg] + 1'b1;
                    end
                    else
                    begin
                        rank_next[pb_reg] = rank_reg[pb_reg] + 1'b1;
                    end
                end
                if (pb_reg == RW'(R - 1))
                begin
                    if (pa_reg == RW'(R - 2))
                    begin
                        state_next = S_SCAN_END;
                    end
                    else
                    begin
                        pa_next = pa_reg + 1'b1;
                        pb_next = RW'(pa_reg + 2'd2);
                    end
                end
                else
                begin
                    pb_next = pb_reg + 1'b1;
                end
            end
            S_SCAN_END:
            begin
                gs_next    = alu_res;
                state_next = S_SCAN_GAP;
            end
            S_SCAN_GAP:
            begin
                gz_next    = alu_res;
                state_next = S_SCAN_FIT;
            end
            S_SCAN_FIT:
            begin
                if (alu_neg)
                begin
                    advance = 1'b1;
                end
                else if (!found_reg)
                begin
                    take    = 1'b1;
                    advance = 1'b1;
                end
                else if (fit_policy_reg == ptfa_pkg::FIT_FIRST)
                begin
                    advance = 1'b1;
                end
                else
                begin
                    state_next = S_SCAN_PICK;
                end
            end
            S_SCAN_PICK:
            begin
                // Ties keep the lower gap for both policies.
                if (fit_policy_reg == ptfa_pkg::FIT_BEST)
                begin
                    take = alu_neg;
                end
                else
                begin
                    take = !alu_neg && !alu_zero;
                end
                advance = 1'b1;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    bytes_out_next = req_bytes_reg;
                    state_next     = S_IDLE;
                    if (found_reg)
                    begin
                        status_next = ptfa_pkg::STAT_CREATED;
                        slot_next   = free_slot;
                        start_next  = best_start_reg;
                        tbl_we      = 1'b1;
                    end
                    else
                    begin
                        status_next = ptfa_pkg::STAT_NO_SPACE;
                        slot_next   = '0;
                        start_next  = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (take)
        begin
            found_next      = 1'b1;
            best_size_next  = gz_reg;
            best_start_next = gs_reg[BW-1:0];
        end
        if (advance)
        begin
            if (scan_reg == last_reg)
            begin
                state_next = S_FINISH;
            end
            else
            begin
                scan_next  = scan_reg + 1'b1;
                state_next = S_SCAN_END;
            end
        end

        if (cfg_wr_en)
        begin
            case (cfg_index)
                ptfa_pkg::CFG_DISK_SIZE:
                begin
                    disk_size_next = cfg_data;
                end
                ptfa_pkg::CFG_FIT_POLICY:
                begin
                    fit_policy_next = cfg_data[ptfa_pkg::POLICY_W-1:0];
                end
                default:
                begin
                    disk_size_next = disk_size_reg;
                end
            endcase
        end
    end

    // Sequencer state, scan registers, configuration and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            status_reg     <= ptfa_pkg::STAT_CREATED;
            slot_reg       <= '0;
            start_reg      <= '0;
            bytes_out_reg  <= '0;
            disk_size_reg  <= '0;
            fit_policy_reg <= ptfa_pkg::FIT_WORST;
            for (int k = 0; k < R; k++)
            begin
                rank_reg[k] <= '0;
            end
            pa_reg         <= '0;
            pb_reg         <= '0;
            scan_reg       <= '0;
            last_reg       <= '0;
            gs_reg         <= '0;
            gz_reg         <= '0;
            best_size_reg  <= '0;
            best_start_reg <= '0;
            found_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            slot_reg       <= slot_next;
            start_reg      <= start_next;
            bytes_out_reg  <= bytes_out_next;
            disk_size_reg  <= disk_size_next;
            fit_policy_reg <= fit_policy_next;
            rank_reg       <= rank_next;
            pa_reg         <= pa_next;
            pb_reg         <= pb_next;
            scan_reg       <= scan_next;
            last_reg       <= last_next;
            gs_reg         <= gs_next;
            gz_reg         <= gz_next;
            best_size_reg  <= best_size_next;
            best_start_reg <= best_start_next;
            found_reg      <= found_next;
        end
    end

    // Request capture. Name byte fifteen is always taken as zero.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_bytes_reg     <= conv_ovf ? '0 : conv_bytes;
            req_ovf_reg       <= conv_ovf;
            req_kind_reg      <= part_kind;
            req_tag_reg       <= part_fit_tag;
            req_name_high_reg <= name_high;
            req_name_low_reg  <= {name_low[NW-1:ptfa_pkg::NAME_PAD_W],
                                  {ptfa_pkg::NAME_PAD_W{1'b0}}};
        end
    end

    // Slot sizes double as the in-use flags, so they are cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < S; i++)
            begin
                entry_size_reg[i] <= '0;
            end
        end
        else if (tbl_we)
        begin
            entry_size_reg[free_slot] <= req_bytes_reg;
        end
    end

    // Remaining slot fields only matter once the slot is in use.
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            entry_start_reg[free_slot]     <= best_start_reg;
            entry_ext_reg[free_slot]       <= req_kind_reg;
            entry_tag_reg[free_slot]       <= req_tag_reg;
            entry_name_high_reg[free_slot] <= req_name_high_reg;
            entry_name_low_reg[free_slot]  <= req_name_low_reg;
        end
    end

endmodule

// ===== rtl/core/ptfa_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the partition table fit allocator and its bind.
// Depends on ptfa_pkg and on the partition_table_fit_allocator ports.
module ptfa_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [ptfa_pkg::STATUS_W-1:0]       status,
    input logic [ptfa_pkg::SLOT_IDX_W-1:0]     slot_index,
    input logic [ptfa_pkg::BYTE_W-1:0]         start_byte,
    input logic [ptfa_pkg::BYTE_W-1:0]         byte_size
);

    // A stalled result transaction holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(slot_index) && $stable(start_byte) && $stable(byte_size))
    else $error("result payload changed while stalled");

    // Only one request is worked on at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("request accepted while the previous one was still in work");

    // A rejected request reports neither a slot nor a start.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ptfa_pkg::STAT_CREATED |->
            slot_index == '0 && start_byte == '0)
    else $error("rejected request reports a slot or start");

    // A created partition has a size and starts past the header.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ptfa_pkg::STAT_CREATED |->
            byte_size != '0 && start_byte >= ptfa_pkg::BYTE_W'(ptfa_pkg::HEADER_BYTES))
    else $error("created partition is empty or overlaps the header");

endmodule

bind partition_table_fit_allocator ptfa_checker u_ptfa_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the partition table fit allocator. It drives
// requests and configuration writes and checks every result against a
// scoreboard that tracks the slot table. Depends on ptfa_pkg and the RTL top.

module testbench;

    // Codes that the package leaves out but the fields allow.
    localparam logic [ptfa_pkg::UNIT_W-1:0]   UNIT_MIB      = 2'd2;
    localparam logic [ptfa_pkg::UNIT_W-1:0]   UNIT_ODD      = 2'd3;
    localparam logic                          KIND_PRIMARY  = 1'b0;
    localparam logic [ptfa_pkg::POLICY_W-1:0] FIT_ODD       = 2'd3;

    localparam longint                        BYTE_MAX      = 64'h7FFF_FFFF;
    localparam logic [ptfa_pkg::BYTE_W-1:0]   FULL_DISK     = '1;
    localparam int                            STATUS_KINDS  = 5;

    // The settle time covers the longest placement.
    localparam int                  SETTLE_CYCLES = 32;
    localparam int                  PHASE_COUNT   = 8;
    localparam int                  PHASE_ITEMS   = 225;
    // The limit lies far above the slowest legal run (every gap and stall at
    // its longest).
    localparam int                  CYCLE_LIMIT   = 1500000;

    // One request transaction as seen on the input channel.
    typedef struct packed {
        logic [ptfa_pkg::BYTE_W-1:0] size_value;
        logic [ptfa_pkg::UNIT_W-1:0] size_unit;
        logic                        part_kind;
        logic [ptfa_pkg::TAG_W-1:0]  part_fit_tag;
        logic [ptfa_pkg::NAME_W-1:0] name_high;
        logic [ptfa_pkg::NAME_W-1:0] name_low;
    } request_t;

    // One result transaction as seen on the output channel.
    typedef struct packed {
        ptfa_pkg::status_t               status;
        logic [ptfa_pkg::SLOT_IDX_W-1:0] slot_index;
        logic [ptfa_pkg::BYTE_W-1:0]     start_byte;
        logic [ptfa_pkg::BYTE_W-1:0]     byte_size;
    } outcome_t;

    // The scoreboard keeps its own copy of the slot table and of the two
    // registers, works out the outcome of every accepted request and keeps
    // the outcomes in arrival order until the block delivers them.
    class partition_tracker;
        logic [ptfa_pkg::BYTE_W-1:0]   slot_start   [ptfa_pkg::SLOT_COUNT];
        logic [ptfa_pkg::BYTE_W-1:0]   slot_len     [ptfa_pkg::SLOT_COUNT];
        logic                          slot_ext     [ptfa_pkg::SLOT_COUNT];
        logic [ptfa_pkg::TAG_W-1:0]    slot_tag     [ptfa_pkg::SLOT_COUNT];
        logic [ptfa_pkg::NAME_W-1:0]   slot_name_hi [ptfa_pkg::SLOT_COUNT];
        logic [ptfa_pkg::NAME_W-1:0]   slot_name_lo [ptfa_pkg::SLOT_COUNT];
        logic [ptfa_pkg::BYTE_W-1:0]   disk_bytes;
        logic [ptfa_pkg::POLICY_W-1:0] placement;
        outcome_t pending_outcomes[$];
        int errors;
        int requests;
        int status_hits [STATUS_KINDS];

        function new();
            for (int i = 0; i < ptfa_pkg::SLOT_COUNT; i++)
            begin
                slot_start[i]   = '0;
                slot_len[i]     = '0;
                slot_ext[i]     = 1'b0;
                slot_tag[i]     = '0;
                slot_name_hi[i] = '0;
                slot_name_lo[i] = '0;
            end
            disk_bytes = '0;
            placement  = ptfa_pkg::FIT_WORST;
            errors     = 0;
            requests   = 0;
            for (int i = 0; i < STATUS_KINDS; i++)
                status_hits[i] = 0;
        endfunction

        function void apply_config(logic [ptfa_pkg::CFG_IDX_W-1:0] idx,
                                   logic [ptfa_pkg::CFG_DATA_W-1:0] data);
            if (idx == ptfa_pkg::CFG_DISK_SIZE)
                disk_bytes = data[ptfa_pkg::BYTE_W-1:0];
            else if (idx == ptfa_pkg::CFG_FIT_POLICY)
                placement = data[ptfa_pkg::POLICY_W-1:0];
        endfunction

        // Works out the outcome of one request and updates the table.
        function outcome_t place_partition(request_t rq);
            outcome_t res;
            longint bytes, need, gs, ge, gz, best_start, best_size, s, e;
            longint rs [ptfa_pkg::RANGE_COUNT];
            longint re [ptfa_pkg::RANGE_COUNT];
            logic [ptfa_pkg::NAME_W-1:0] nl;
            bit overflow, found, has_ext;
            int used, n, j, slot;
            // The last name byte never takes part in a comparison.
            nl = {rq.name_low[ptfa_pkg::NAME_W-1:ptfa_pkg::NAME_PAD_W],
                  {ptfa_pkg::NAME_PAD_W{1'b0}}};
            case (rq.size_unit)
                ptfa_pkg::UNIT_BYTE: bytes = longint'(rq.size_value);
                ptfa_pkg::UNIT_KIB:  bytes = longint'(rq.size_value) << ptfa_pkg::KIB_SHIFT;
                default:             bytes = longint'(rq.size_value) << ptfa_pkg::MIB_SHIFT;
            endcase
            overflow = bytes > BYTE_MAX;
            if (overflow)
                bytes = 0;
            res.status     = ptfa_pkg::STAT_NO_SPACE;
            res.slot_index = '0;
            res.start_byte = '0;
            res.byte_size  = bytes[ptfa_pkg::BYTE_W-1:0];

            for (int i = 0; i < ptfa_pkg::SLOT_COUNT; i++)
            begin
                if (slot_len[i] != 0 && slot_name_hi[i] == rq.name_high
                    && slot_name_lo[i] == nl)
                begin
                    res.status = ptfa_pkg::STAT_DUP_NAME;
                    return res;
                end
            end
            used = 0;
            has_ext = 1'b0;
            for (int i = 0; i < ptfa_pkg::SLOT_COUNT; i++)
            begin
                if (slot_len[i] != 0)
                begin
                    used++;
                    if (slot_ext[i])
                        has_ext = 1'b1;
                end
            end
            if (used >= ptfa_pkg::SLOT_COUNT)
            begin
                res.status = ptfa_pkg::STAT_TABLE_FULL;
                return res;
            end
            if (rq.part_kind == ptfa_pkg::KIND_EXTENDED && has_ext)
            begin
                res.status = ptfa_pkg::STAT_EXT_EXISTS;
                return res;
            end
            if (overflow || bytes == 0)
                return res;
            need = bytes;

            // Used ranges sorted by start, header first, equal starts kept in order.
            rs[0] = 0;
            re[0] = longint'(ptfa_pkg::HEADER_BYTES);
            n = 1;
            for (int i = 0; i < ptfa_pkg::SLOT_COUNT; i++)
            begin
                if (slot_len[i] != 0)
                begin
                    s = longint'(slot_start[i]);
                    e = s + longint'(slot_len[i]);
                    j = n;
                    while (j > 0 && rs[j-1] > s)
                    begin
                        rs[j] = rs[j-1];
                        re[j] = re[j-1];
                        j--;
                    end
                    rs[j] = s;
                    re[j] = e;
                    n++;
                end
            end

            found = 1'b0;
            best_start = 0;
            best_size = 0;
            for (int i = 0; i < n; i++)
            begin
                gs = re[i];
                ge = (i + 1 < n) ? rs[i+1] : longint'(disk_bytes);
                gz = ge - gs;
                if (gz >= need)
                begin
                    if (!found)
                    begin
                        found = 1'b1;
                        best_start = gs;
                        best_size = gz;
                    end
                    else if (placement == ptfa_pkg::FIT_BEST)
                    begin
                        if (gz < best_size)
                        begin
                            best_size = gz;
                            best_start = gs;
                        end
                    end
                    else if (placement != ptfa_pkg::FIT_FIRST)
                    begin
                        if (gz > best_size)
                        begin
                            best_size = gz;
                            best_start = gs;
                        end
                    end
                end
            end
            if (!found)
                return res;

            slot = -1;
            for (int i = ptfa_pkg::SLOT_COUNT - 1; i >= 0; i--)
                if (slot_len[i] == 0)
                    slot = i;
            slot_start[slot]   = best_start[ptfa_pkg::BYTE_W-1:0];
            slot_len[slot]     = bytes[ptfa_pkg::BYTE_W-1:0];
            slot_ext[slot]     = rq.part_kind;
            slot_tag[slot]     = rq.part_fit_tag;
            slot_name_hi[slot] = rq.name_high;
            slot_name_lo[slot] = nl;
            res.status     = ptfa_pkg::STAT_CREATED;
            res.slot_index = slot[ptfa_pkg::SLOT_IDX_W-1:0];
            res.start_byte = best_start[ptfa_pkg::BYTE_W-1:0];
            return res;
        endfunction

        function void note_request(request_t rq);
            outcome_t res;
            res = place_partition(rq);
            pending_outcomes.insert(pending_outcomes.size(), res);
            status_hits[res.status]++;
            requests++;
        endfunction

        function void check_result(outcome_t act);
            outcome_t exp;
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: result with no request outstanding, status %0d start %0d",
                         $time, act.status, act.start_byte);
                errors++;
                return;
            end
            exp = pending_outcomes.pop_front();
            if (act.status != exp.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, exp.status, act.status);
                errors++;
            end
            if (act.slot_index != exp.slot_index)
            begin
                $display("%0t: slot_index expected %0d actual %0d",
                         $time, exp.slot_index, act.slot_index);
                errors++;
            end
            if (act.start_byte != exp.start_byte)
            begin
                $display("%0t: start_byte expected %0d actual %0d",
                         $time, exp.start_byte, act.start_byte);
                errors++;
            end
            if (act.byte_size != exp.byte_size)
            begin
                $display("%0t: byte_size expected %0d actual %0d",
                         $time, exp.byte_size, act.byte_size);
                errors++;
            end
        endfunction

        function int pending_count();
            return pending_outcomes.size();
        endfunction

        // End of the used area, never below the header.
        function logic [ptfa_pkg::BYTE_W-1:0] used_end();
            longint top, e;
            top = longint'(ptfa_pkg::HEADER_BYTES);
            for (int i = 0; i < ptfa_pkg::SLOT_COUNT; i++)
            begin
                e = longint'(slot_start[i]) + longint'(slot_len[i]);
                if (slot_len[i] != 0 && e > top)
                    top = e;
            end
            if (top > BYTE_MAX)
                top = BYTE_MAX;
            return top[ptfa_pkg::BYTE_W-1:0];
        endfunction

        function logic [2*ptfa_pkg::NAME_W-1:0] slot_name(int i);
            return {slot_name_hi[i], slot_name_lo[i]};
        endfunction

        function void finish_report();
            if (pending_outcomes.size() != 0)
            begin
                $display("%0t: %0d expected results never arrived",
                         $time, pending_outcomes.size());
                errors += pending_outcomes.size();
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [ptfa_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ptfa_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic [ptfa_pkg::BYTE_W-1:0]     size_value;
    logic [ptfa_pkg::UNIT_W-1:0]     size_unit;
    logic                            part_kind;
    logic [ptfa_pkg::TAG_W-1:0]      part_fit_tag;
    logic [ptfa_pkg::NAME_W-1:0]     name_high;
    logic [ptfa_pkg::NAME_W-1:0]     name_low;
    logic                            out_valid;
    logic                            out_stall;
    logic [ptfa_pkg::STATUS_W-1:0]   status;
    logic [ptfa_pkg::SLOT_IDX_W-1:0] slot_index;
    logic [ptfa_pkg::BYTE_W-1:0]     start_byte;
    logic [ptfa_pkg::BYTE_W-1:0]     byte_size;

    partition_tracker tracker;
    // When set, neither side inserts gaps or stalls.
    bit calm;
    int cycle_count;

    partition_table_fit_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .size_value   (size_value),
        .size_unit    (size_unit),
        .part_kind    (part_kind),
        .part_fit_tag (part_fit_tag),
        .name_high    (name_high),
        .name_low     (name_low),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .slot_index   (slot_index),
        .start_byte   (start_byte),
        .byte_size    (byte_size)
    );

    initial
        clk = 1'b0;

    always #1 clk = ~clk;

    // Every input starts at a known value, with reset asserted.
    initial
    begin
        tracker      = new();
        calm         = 1'b0;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        size_value   = '0;
        size_unit    = '0;
        part_kind    = 1'b0;
        part_fit_tag = '0;
        name_high    = '0;
        name_low     = '0;
        out_stall    = 1'b0;
    end

    // Both channels are observed at the rising edge, before the block's own
    // registers move, so the scoreboard sees exactly what the block sees.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.note_request({size_value, size_unit, part_kind, part_fit_tag,
                                      name_high, name_low});
            if (out_valid && !out_stall)
                tracker.check_result({ptfa_pkg::status_t'(status), slot_index,
                                      start_byte, byte_size});
        end
    end

    // Gap length shared by both sides: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // The result side alternates stall stretches with free stretches.
    initial
    begin
        int stall_len;
        int free_len;
        wait (rst_n === 1'b1);
        forever
        begin
            stall_len = pick_gap();
            free_len = $urandom_range(1, 8);
            repeat (stall_len)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            repeat (free_len)
            begin
                @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Safety net against a hung handshake.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run stopped after %0d cycles", $time, CYCLE_LIMIT);
        $display("** partition_table_fit_allocator: FAILED **");
        $finish;
    end

    function automatic request_t make_request(logic [ptfa_pkg::BYTE_W-1:0] value,
                                              logic [ptfa_pkg::UNIT_W-1:0] unit,
                                              logic kind,
                                              logic [ptfa_pkg::NAME_W-1:0] nh,
                                              logic [ptfa_pkg::NAME_W-1:0] nl);
        request_t rq;
        rq.size_value   = value;
        rq.size_unit    = unit;
        rq.part_kind    = kind;
        rq.part_fit_tag = ptfa_pkg::TAG_W'($urandom_range(0, 3));
        rq.name_high    = nh;
        rq.name_low     = nl;
        return rq;
    endfunction

    // Presents one request and holds it until the block takes it. Valid
    // stays high into the next request unless a pause lowers it.
    task automatic send_request(input request_t rq);
        @(negedge clk);
        in_valid     <= 1'b1;
        size_value   <= rq.size_value;
        size_unit    <= rq.size_unit;
        part_kind    <= rq.part_kind;
        part_fit_tag <= rq.part_fit_tag;
        name_high    <= rq.name_high;
        name_low     <= rq.name_low;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
    endtask

    task automatic sender_pause(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    // Holds off new requests until every outstanding result has come back
    // and the block has had time to settle.
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending_count() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Writes both registers with the block idle. The upper bits of the
    // policy word are don't-care and are driven at random.
    task automatic configure(input logic [ptfa_pkg::BYTE_W-1:0] disk,
                             input logic [ptfa_pkg::POLICY_W-1:0] policy);
        logic [ptfa_pkg::CFG_DATA_W-1:0] policy_word;
        policy_word = {$urandom_range(0, 1) ? 29'h1FFF_FFFF : 29'($urandom), policy};
        wait_for_results();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= ptfa_pkg::CFG_DISK_SIZE;
        cfg_data  <= disk;
        @(negedge clk);
        cfg_index <= ptfa_pkg::CFG_FIT_POLICY;
        cfg_data  <= policy_word;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        tracker.apply_config(ptfa_pkg::CFG_DISK_SIZE, disk);
        tracker.apply_config(ptfa_pkg::CFG_FIT_POLICY, policy_word);
    endtask

    // Random request: names often repeat a stored one (with a random last
    // byte) to reach the duplicate check; sizes span tiny, huge and
    // overflowing values in every unit.
    function automatic request_t random_request();
        request_t rq;
        logic [2*ptfa_pkg::NAME_W-1:0] stored;
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            stored = tracker.slot_name($urandom_range(0, ptfa_pkg::SLOT_COUNT - 1));
            rq.name_high = stored[2*ptfa_pkg::NAME_W-1:ptfa_pkg::NAME_W];
            rq.name_low  = {stored[ptfa_pkg::NAME_W-1:ptfa_pkg::NAME_PAD_W], 8'($urandom)};
        end
        else if (r < 45)
        begin
            rq.name_high = '0;
            rq.name_low  = {56'd0, 8'($urandom)};
        end
        else if (r < 50)
        begin
            rq.name_high = '1;
            rq.name_low  = '1;
        end
        else
        begin
            rq.name_high = {$urandom, $urandom};
            rq.name_low  = {$urandom, $urandom};
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            rq.size_value = '0;
            rq.size_unit  = ptfa_pkg::UNIT_W'($urandom_range(0, 3));
        end
        else if (r < 15)
        begin
            rq.size_value = ptfa_pkg::BYTE_W'($urandom) | 31'h4000_0000;
            rq.size_unit  = ptfa_pkg::UNIT_W'($urandom_range(1, 3));
        end
        else if (r < 50)
        begin
            rq.size_value = ptfa_pkg::BYTE_W'($urandom_range(1, 4096));
            rq.size_unit  = ptfa_pkg::UNIT_BYTE;
        end
        else if (r < 65)
        begin
            rq.size_value = ptfa_pkg::BYTE_W'($urandom);
            rq.size_unit  = ptfa_pkg::UNIT_BYTE;
        end
        else if (r < 80)
        begin
            rq.size_value = ptfa_pkg::BYTE_W'($urandom_range(1, 64));
            rq.size_unit  = ptfa_pkg::UNIT_KIB;
        end
        else if (r < 90)
        begin
            rq.size_value = ptfa_pkg::BYTE_W'($urandom_range(1, 8));
            rq.size_unit  = $urandom_range(0, 1) ? UNIT_MIB : UNIT_ODD;
        end
        else
        begin
            rq.size_value = ptfa_pkg::BYTE_W'($urandom);
            rq.size_unit  = ptfa_pkg::UNIT_W'($urandom_range(0, 3));
        end
        rq.part_kind    = ($urandom_range(0, 4) == 0) ? ptfa_pkg::KIND_EXTENDED : KIND_PRIMARY;
        rq.part_fit_tag = ptfa_pkg::TAG_W'($urandom_range(0, 3));
        return rq;
    endfunction

    // Each random phase sets a disk size relative to the used area, at random or
    // at an extreme, together with one of the four policy codes.
    task automatic start_phase(input int phase);
        case (phase)
            0: configure(tracker.used_end(), ptfa_pkg::FIT_FIRST);
            1: configure(tracker.used_end() + ptfa_pkg::BYTE_W'($urandom_range(1, 64)),
                         ptfa_pkg::FIT_BEST);
            2: configure('0, ptfa_pkg::FIT_WORST);
            3: configure(ptfa_pkg::BYTE_W'(ptfa_pkg::HEADER_BYTES - 1), FIT_ODD);
            4: configure(tracker.used_end() + ptfa_pkg::BYTE_W'($urandom_range(0, 8192)),
                         ptfa_pkg::FIT_FIRST);
            5: configure(ptfa_pkg::BYTE_W'($urandom), ptfa_pkg::FIT_BEST);
            6: configure(FULL_DISK, ptfa_pkg::FIT_WORST);
            default: configure(FULL_DISK, ptfa_pkg::POLICY_W'($urandom_range(0, 3)));
        endcase
        // Two phases run with no random gaps or stalls on either side.
        calm = (phase == 3 || phase == 7);
    endtask

    initial
    begin
        int gap;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. The first request runs on the reset register
        // values, where the disk is smaller than the header.
        send_request(make_request(31'd100, ptfa_pkg::UNIT_BYTE, KIND_PRIMARY,
                                  64'h4E41_4D45_5F41_5F30, 64'h0));
        // A disk one byte short of the header, then exactly the header.
        configure(ptfa_pkg::BYTE_W'(ptfa_pkg::HEADER_BYTES - 1), ptfa_pkg::FIT_FIRST);
        send_request(make_request(31'd1, ptfa_pkg::UNIT_BYTE, KIND_PRIMARY, 64'h1, 64'h0));
        configure(ptfa_pkg::BYTE_W'(ptfa_pkg::HEADER_BYTES), ptfa_pkg::FIT_BEST);
        send_request(make_request(31'd1, ptfa_pkg::UNIT_BYTE, KIND_PRIMARY, 64'h1, 64'h0));

        // Largest disk with the undefined policy code, which acts as worst
        // fit. Zero size, the largest byte size and three kinds of overflow.
        configure(FULL_DISK, FIT_ODD);
        send_request(make_request(31'd0, ptfa_pkg::UNIT_BYTE, KIND_PRIMARY, 64'h2, 64'h0));
        send_request(make_request(FULL_DISK, ptfa_pkg::UNIT_BYTE, KIND_PRIMARY, 64'h2, 64'h0));
        send_request(make_request(31'h0020_0000, ptfa_pkg::UNIT_KIB, KIND_PRIMARY,
                                  64'h2, 64'h0));
        send_request(make_request(31'd2048, UNIT_MIB, KIND_PRIMARY, 64'h2, 64'h0));
        send_request(make_request(FULL_DISK, UNIT_ODD, KIND_PRIMARY, 64'h2, 64'h0));
        // Unit code three counts as mebibytes; the name's last byte is set
        // and must be dropped when stored.
        send_request(make_request(31'd1, UNIT_ODD, KIND_PRIMARY,
                                  64'h5041_5254_5F5A_4552, 64'h4F5F_4F4E_4500_00FF));
        // Same name with a different last byte is a duplicate, and the
        // duplicate check comes ahead of the zero-size check.
        send_request(make_request(31'd0, ptfa_pkg::UNIT_BYTE, ptfa_pkg::KIND_EXTENDED,
                                  64'h5041_5254_5F5A_4552, 64'h4F5F_4F4E_4500_0000));
        send_request(make_request(31'd4096, ptfa_pkg::UNIT_BYTE, ptfa_pkg::KIND_EXTENDED,
                                  64'h4558_5445_4E44_4544, 64'h0));
        // A second extended partition is refused, even with a bad size.
        send_request(make_request(31'd1, ptfa_pkg::UNIT_BYTE, ptfa_pkg::KIND_EXTENDED,
                                  64'h3, 64'h0));
        send_request(make_request(31'd0, ptfa_pkg::UNIT_KIB, ptfa_pkg::KIND_EXTENDED,
                                  64'h3, 64'h0));
        // An all-zero name matches the free slots' names, which must not
        // count as duplicates.
        send_request(make_request(31'h0020_0000, ptfa_pkg::UNIT_KIB, KIND_PRIMARY,
                                  64'h0, 64'h0));
        send_request(make_request(31'd0, ptfa_pkg::UNIT_BYTE, KIND_PRIMARY, 64'h0, 64'h0));

        // Disk ends right at the used area, then one byte past it.
        configure(tracker.used_end(), ptfa_pkg::FIT_WORST);
        send_request(make_request(31'd1, ptfa_pkg::UNIT_BYTE, KIND_PRIMARY, '1, '1));
        configure(tracker.used_end() + 31'd1, ptfa_pkg::FIT_FIRST);
        send_request(make_request(31'd2, ptfa_pkg::UNIT_BYTE, KIND_PRIMARY, '1, '1));
        send_request(make_request(31'd1, ptfa_pkg::UNIT_KIB, KIND_PRIMARY, '1, '1));
        // Disk ends inside the used area, so the last gap is inverted.
        configure(ptfa_pkg::BYTE_W'(ptfa_pkg::HEADER_BYTES + 100), ptfa_pkg::FIT_BEST);
        send_request(make_request(31'd1, ptfa_pkg::UNIT_BYTE, KIND_PRIMARY, 64'h4, 64'h0));

        // Random part in phases, each with its own register settings. Now
        // and then the sender holds off until every result is back.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            start_phase(phase);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                gap = pick_gap();
                if (gap > 0)
                    sender_pause(gap);
                if ($urandom_range(0, 63) == 0)
                    wait_for_results();
                send_request(random_request());
            end
        end

        wait_for_results();
        tracker.finish_report();
        $display("%0d requests: %0d created, %0d duplicate, %0d table full,",
                 tracker.requests, tracker.status_hits[ptfa_pkg::STAT_CREATED],
                 tracker.status_hits[ptfa_pkg::STAT_DUP_NAME],
                 tracker.status_hits[ptfa_pkg::STAT_TABLE_FULL]);
        $display("%0d extended taken, %0d no space; %0d register phases, disk sizes %s",
                 tracker.status_hits[ptfa_pkg::STAT_EXT_EXISTS],
                 tracker.status_hits[ptfa_pkg::STAT_NO_SPACE], PHASE_COUNT + 6,
                 "from zero to full scale, policy codes 0 to 3");
        if (tracker.errors == 0)
            $display("** partition_table_fit_allocator: PASSED **");
        else
            $display("** partition_table_fit_allocator: FAILED **");
        $finish;
    end

endmodule
